[sv/q8sf_pkg.sv]
// ----------------------------------------------------------------------------
// q8sf_pkg
// Constants, types and helpers for the eight-node serendipity shape function
// evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package q8sf_pkg;

  localparam int FRAC_BITS = 14;
  localparam int COORD_W   = 16;
  localparam int OUT_W     = 17;
  localparam int NODE_W    = 3;
  localparam int LANES     = 3;

  // signed factor width and unsigned magnitude width (|factor| < 4.0)
  localparam int FW  = FRAC_BITS + 4;
  localparam int MW  = FRAC_BITS + 2;
  localparam int PW1 = 2 * MW;
  localparam int PW2 = 3 * MW;

  localparam logic signed [FW-1:0] ONE = FW'(1) <<< FRAC_BITS;

  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(7);

  localparam int SHIFT_Q = 3 * FRAC_BITS + 2;  // x 1/4
  localparam int SHIFT_H = 3 * FRAC_BITS + 1;  // x 1/2
  localparam int SHIFT_W = 3 * FRAC_BITS;      // x 1

  localparam logic [PW2:0] HALF_Q = (PW2 + 1)'(1) << (SHIFT_Q - 1);
  localparam logic [PW2:0] HALF_H = (PW2 + 1)'(1) << (SHIFT_H - 1);
  localparam logic [PW2:0] HALF_W = (PW2 + 1)'(1) << (SHIFT_W - 1);

  typedef enum logic [1:0] {
    SH_Q,
    SH_H,
    SH_W
  } shift_e;

  typedef struct packed {
    logic            neg;
    logic [MW-1:0]   ma;
    logic [MW-1:0]   mb;
    logic [MW-1:0]   mc;
    shift_e          sh;
  } lane_t;

  function automatic logic signed [FW-1:0] sat_coord(input logic [COORD_W-1:0] raw);
    logic signed [FW-1:0] v;
    v = {{(FW - COORD_W){raw[COORD_W-1]}}, raw};
    if (v > ONE) begin
      v = ONE;
    end else if (v < -ONE) begin
      v = -ONE;
    end
    return v;
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [FW-1:0] v);
    logic signed [FW-1:0] a;
    a = v[FW-1] ? -v : v;
    return a[MW-1:0];
  endfunction

  function automatic lane_t mk_lane(input logic signed [FW-1:0] a,
                                    input logic signed [FW-1:0] b,
                                    input logic signed [FW-1:0] c,
                                    input shift_e               sh);
    lane_t l;
    l.neg = a[FW-1] ^ b[FW-1] ^ c[FW-1];
    l.ma  = mag(a);
    l.mb  = mag(b);
    l.mc  = mag(c);
    l.sh  = sh;
    return l;
  endfunction

endpackage

`default_nettype wire

[sv/quad8_shape_function_eval.sv]
// ----------------------------------------------------------------------------
// quad8_shape_function_eval
// Eight-node serendipity quad: shape values and xi/eta gradients of all
// eight nodes at one natural-coordinate point, one node result per cycle.
// ----------------------------------------------------------------------------
//  Channel   Ports                                        Handshake
//  point     xi_coord_i, eta_coord_i                      start / busy
//  result    node_index_o, shape_value_o, grad_xi_o,      result_valid_o strobe
//            grad_eta_o, last_node_o
//
//  The node sequencer issues one node per cycle into the shared product
//  pipeline, feeding the single result port. Node 0 shows after the factor,
//  first product, full product and result registers; the next point is taken in
//  the cycle node 7 issues. Reset clears the sequencer and the pipeline valid bits.
//  The receiver cannot stall; results are dropped onto the port as they finish.
// ----------------------------------------------------------------------------
`default_nettype none

module quad8_shape_function_eval import q8sf_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [COORD_W-1:0] xi_coord_i,
  input  wire logic signed [COORD_W-1:0] eta_coord_i,
  output logic                           result_valid_o,
  output logic [NODE_W-1:0]              node_index_o,
  output logic signed [OUT_W-1:0]        shape_value_o,
  output logic signed [OUT_W-1:0]        grad_xi_o,
  output logic signed [OUT_W-1:0]        grad_eta_o,
  output logic                           last_node_o
);

  // sequencer
  logic                    act_q, act_d;
  logic [NODE_W-1:0]       node_q, node_d;
  logic signed [FW-1:0]    x_q, x_d, e_q, e_d;
  logic                    accept;

  // stage 1: factor magnitudes
  logic                    v1_q;
  logic [NODE_W-1:0]       node1_q;
  lane_t                   l1_q [LANES];
  lane_t                   l1_d [LANES];

  // stage 2: first product
  logic                    v2_q;
  logic [NODE_W-1:0]       node2_q;
  logic                    neg2_q [LANES];
  logic [PW1-1:0]          p1_q   [LANES];
  logic [MW-1:0]           mc2_q  [LANES];
  shift_e                  sh2_q  [LANES];

  // stage 3: full product
  logic                    v3_q;
  logic [NODE_W-1:0]       node3_q;
  logic                    neg3_q [LANES];
  logic [PW2-1:0]          p2_q   [LANES];
  shift_e                  sh3_q  [LANES];

  // stage 4: rounded results
  logic                    v4_q;
  logic [NODE_W-1:0]       node4_q;
  logic [OUT_W-1:0]        res_q [LANES];
  logic [OUT_W-1:0]        res_d [LANES];

  logic signed [FW-1:0] opx, omx, ope, ome, xmo, emo, tx, te;

  assign busy   = act_q && (node_q != LAST_NODE);
  assign accept = start && !busy;

  always_comb begin
    act_d  = act_q;
    node_d = node_q;
    x_d    = x_q;
    e_d    = e_q;
    if (accept) begin
      act_d  = 1'b1;
      node_d = '0;
      x_d    = sat_coord(xi_coord_i);
      e_d    = sat_coord(eta_coord_i);
    end else if (act_q) begin
      if (node_q == LAST_NODE) begin
        act_d = 1'b0;
      end else begin
        node_d = node_q + NODE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      node_q <= '0;
    end else begin
      act_q  <= act_d;
      node_q <= node_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    e_q <= e_d;
  end

  // linear factors of the point
  assign opx = ONE + x_q;
  assign omx = ONE - x_q;
  assign ope = ONE + e_q;
  assign ome = ONE - e_q;
  assign xmo = x_q - ONE;
  assign emo = e_q - ONE;
  assign tx  = x_q + x_q;
  assign te  = e_q + e_q;

  // lane 0: shape, lane 1: d/dxi, lane 2: d/deta
  always_comb begin
    case (node_q)
      3'd0: begin
        l1_d[0] = mk_lane(omx, ome, -ONE - x_q - e_q, SH_Q);
        l1_d[1] = mk_lane(ome, tx + e_q, ONE, SH_Q);
        l1_d[2] = mk_lane(omx, x_q + te, ONE, SH_Q);
      end
      3'd1: begin
        l1_d[0] = mk_lane(opx, ome, -ONE + x_q - e_q, SH_Q);
        l1_d[1] = mk_lane(ome, tx - e_q, ONE, SH_Q);
        l1_d[2] = mk_lane(opx, te - x_q, ONE, SH_Q);
      end
      3'd2: begin
        l1_d[0] = mk_lane(opx, ope, -ONE + x_q + e_q, SH_Q);
        l1_d[1] = mk_lane(ope, tx + e_q, ONE, SH_Q);
        l1_d[2] = mk_lane(opx, x_q + te, ONE, SH_Q);
      end
      3'd3: begin
        l1_d[0] = mk_lane(omx, ope, -ONE - x_q + e_q, SH_Q);
        l1_d[1] = mk_lane(ope, tx - e_q, ONE, SH_Q);
        l1_d[2] = mk_lane(omx, te - x_q, ONE, SH_Q);
      end
      3'd4: begin
        l1_d[0] = mk_lane(omx, opx, ome, SH_H);
        l1_d[1] = mk_lane(x_q, emo, ONE, SH_W);
        l1_d[2] = mk_lane(xmo, x_q + ONE, ONE, SH_H);
      end
      3'd5: begin
        l1_d[0] = mk_lane(opx, ome, ope, SH_H);
        l1_d[1] = mk_lane(ome, ope, ONE, SH_H);
        l1_d[2] = mk_lane(opx, -e_q, ONE, SH_W);
      end
      3'd6: begin
        l1_d[0] = mk_lane(omx, opx, ope, SH_H);
        l1_d[1] = mk_lane(-x_q, ope, ONE, SH_W);
        l1_d[2] = mk_lane(omx, opx, ONE, SH_H);
      end
      default: begin
        l1_d[0] = mk_lane(omx, ome, ope, SH_H);
        l1_d[1] = mk_lane(emo, e_q + ONE, ONE, SH_H);
        l1_d[2] = mk_lane(xmo, e_q, ONE, SH_W);
      end
    endcase
  end

  // round half away from zero on the magnitude, then restore sign
  always_comb begin
    logic [PW2:0] rnd;
    logic [OUT_W-1:0] m;
    for (int i = 0; i < LANES; i++) begin
      case (sh3_q[i])
        SH_Q:    rnd = ({1'b0, p2_q[i]} + HALF_Q) >> SHIFT_Q;
        SH_H:    rnd = ({1'b0, p2_q[i]} + HALF_H) >> SHIFT_H;
        SH_W:    rnd = ({1'b0, p2_q[i]} + HALF_W) >> SHIFT_W;
        default: rnd = '0;
      endcase
      m = rnd[OUT_W-1:0];
      res_d[i] = neg3_q[i] ? -m : m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= act_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    node1_q <= node_q;
    node2_q <= node1_q;
    node3_q <= node2_q;
    node4_q <= node3_q;
    for (int i = 0; i < LANES; i++) begin
      l1_q[i]   <= l1_d[i];
      neg2_q[i] <= l1_q[i].neg;
      p1_q[i]   <= l1_q[i].ma * l1_q[i].mb;
      mc2_q[i]  <= l1_q[i].mc;
      sh2_q[i]  <= l1_q[i].sh;
      neg3_q[i] <= neg2_q[i];
      p2_q[i]   <= PW2'(p1_q[i]) * PW2'(mc2_q[i]);
      sh3_q[i]  <= sh2_q[i];
      res_q[i]  <= res_d[i];
    end
  end

  assign result_valid_o = v4_q;
  assign node_index_o   = node4_q;
  assign shape_value_o  = res_q[0];
  assign grad_xi_o      = res_q[1];
  assign grad_eta_o     = res_q[2];
  assign last_node_o    = (node4_q == LAST_NODE);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted item");

  a_first_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 (result_valid_o && (node_index_o == '0)))
    else $error("node 0 result missing after accept");

  a_node_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_node_o) |=>
      (result_valid_o && (node_index_o == $past(node_index_o) + NODE_W'(1))))
    else $error("node results not consecutive");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_node_o == (node_index_o == LAST_NODE)))
    else $error("last flag mismatch");

endmodule

`default_nettype wire

[tb/quad8_shape_function_eval_tb.sv]
// ----------------------------------------------------------------------------
// quad8_shape_function_eval_tb
// Drives natural-coordinate points into the serendipity shape function block
// and checks all eight node results of each point against a fixed-point
// model of N_k, dN_k/dxi and dN_k/deta, rounded half away from zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quad8_shape_function_eval_tb;
  import q8sf_pkg::*;

  localparam int NODES      = 8;
  localparam int RAND_ITEMS = 480;
  localparam int DRAIN      = 20;
  localparam int STALL_MAX  = 2000;

  typedef struct {
    logic [COORD_W-1:0] xi;
    logic [COORD_W-1:0] eta;
    int                 idle_pct;
  } point_item_t;

  typedef struct {
    logic [NODE_W-1:0]       node;
    logic signed [OUT_W-1:0] shape;
    logic signed [OUT_W-1:0] dxi;
    logic signed [OUT_W-1:0] deta;
    logic                    last;
  } node_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic signed [COORD_W-1:0]  xi_coord_i = '0;
  logic signed [COORD_W-1:0]  eta_coord_i = '0;
  logic                       result_valid_o;
  logic [NODE_W-1:0]          node_index_o;
  logic signed [OUT_W-1:0]    shape_value_o;
  logic signed [OUT_W-1:0]    grad_xi_o;
  logic signed [OUT_W-1:0]    grad_eta_o;
  logic                       last_node_o;

  point_item_t  point_q[$];
  node_result_t node_results_q[$];
  int           points_left = 0;
  int           stall_cycles = 0;
  bit           failed = 1'b0;

  quad8_shape_function_eval uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .xi_coord_i     (xi_coord_i),
    .eta_coord_i    (eta_coord_i),
    .result_valid_o (result_valid_o),
    .node_index_o   (node_index_o),
    .shape_value_o  (shape_value_o),
    .grad_xi_o      (grad_xi_o),
    .grad_eta_o     (grad_eta_o),
    .last_node_o    (last_node_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // (a*b*c) / 2^k, rounded half away from zero
  function automatic longint round_prod(input longint a, input longint b,
                                        input longint c, input int k);
    longint p;
    longint m;
    p = a * b * c;
    m = (p < 0) ? -p : p;
    m = (m + (longint'(1) << (k - 1))) >>> k;
    return (p < 0) ? -m : m;
  endfunction

  function automatic longint clamp_coord(input logic [COORD_W-1:0] raw,
                                         input longint one);
    longint v;
    v = longint'($signed(raw));
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v;
  endfunction

  task automatic eval_serendipity(input logic [COORD_W-1:0] xi_raw,
                                  input logic [COORD_W-1:0] eta_raw);
    longint       one;
    longint       x;
    longint       e;
    longint       nv[NODES];
    longint       gx[NODES];
    longint       ge[NODES];
    node_result_t r;
    one = longint'(1) << FRAC_BITS;
    x = clamp_coord(xi_raw, one);
    e = clamp_coord(eta_raw, one);

    nv[0] = round_prod(one - x, one - e, -one - x - e, SHIFT_Q);
    nv[1] = round_prod(one + x, one - e, -one + x - e, SHIFT_Q);
    nv[2] = round_prod(one + x, one + e, -one + x + e, SHIFT_Q);
    nv[3] = round_prod(one - x, one + e, -one - x + e, SHIFT_Q);
    nv[4] = round_prod(one - x, one + x, one - e, SHIFT_H);
    nv[5] = round_prod(one + x, one - e, one + e, SHIFT_H);
    nv[6] = round_prod(one - x, one + x, one + e, SHIFT_H);
    nv[7] = round_prod(one - x, one - e, one + e, SHIFT_H);

    gx[0] = round_prod(one - e, 2 * x + e, one, SHIFT_Q);
    ge[0] = round_prod(one - x, x + 2 * e, one, SHIFT_Q);
    gx[1] = round_prod(one - e, 2 * x - e, one, SHIFT_Q);
    ge[1] = round_prod(one + x, 2 * e - x, one, SHIFT_Q);
    gx[2] = round_prod(one + e, 2 * x + e, one, SHIFT_Q);
    ge[2] = round_prod(one + x, x + 2 * e, one, SHIFT_Q);
    gx[3] = round_prod(one + e, 2 * x - e, one, SHIFT_Q);
    ge[3] = round_prod(one - x, 2 * e - x, one, SHIFT_Q);
    gx[4] = round_prod(x, e - one, one, SHIFT_W);
    ge[4] = round_prod(x - one, x + one, one, SHIFT_H);
    gx[5] = round_prod(one - e, one + e, one, SHIFT_H);
    ge[5] = round_prod(one + x, -e, one, SHIFT_W);
    gx[6] = round_prod(-x, one + e, one, SHIFT_W);
    ge[6] = round_prod(one - x, one + x, one, SHIFT_H);
    gx[7] = round_prod(e - one, e + one, one, SHIFT_H);
    ge[7] = round_prod(x - one, e, one, SHIFT_W);

    for (int k = 0; k < NODES; k++) begin
      r.node  = NODE_W'(k);
      r.shape = OUT_W'(nv[k]);
      r.dxi   = OUT_W'(gx[k]);
      r.deta  = OUT_W'(ge[k]);
      r.last  = (NODE_W'(k) == LAST_NODE);
      node_results_q.push_back(r);
    end
  endtask

  task automatic add_point(input int xi, input int eta, input int idle_pct);
    point_item_t p;
    p.xi       = COORD_W'(xi);
    p.eta      = COORD_W'(eta);
    p.idle_pct = idle_pct;
    point_q.push_back(p);
    points_left++;
  endtask

  function automatic int rand_coord();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return int'($signed(COORD_W'($urandom)));
    if (sel == 1) return (int'($urandom_range(2)) - 1) * 16384;
    return int'($urandom_range(32768)) - 16384;
  endfunction

  // driver: present queued points, hold while busy
  always @(posedge clk_i) begin
    point_item_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold current point
    end else begin
      if (start) begin
        eval_serendipity(xi_coord_i, eta_coord_i);
        points_left--;
      end
      if (point_q.size() != 0 && $urandom_range(99) >= point_q[0].idle_pct) begin
        nxt = point_q.pop_front();
        start       <= 1'b1;
        xi_coord_i  <= nxt.xi;
        eta_coord_i <= nxt.eta;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    node_result_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (node_results_q.size() == 0) begin
        $error("node result with no item outstanding: node %0d", node_index_o);
        failed = 1'b1;
      end else begin
        want = node_results_q.pop_front();
        if (node_index_o !== want.node) begin
          $error("node_index: expected %0d, got %0d", want.node, node_index_o);
          failed = 1'b1;
        end
        if (shape_value_o !== want.shape) begin
          $error("shape_value: expected %0d, got %0d", want.shape, shape_value_o);
          failed = 1'b1;
        end
        if (grad_xi_o !== want.dxi) begin
          $error("grad_xi: expected %0d, got %0d", want.dxi, grad_xi_o);
          failed = 1'b1;
        end
        if (grad_eta_o !== want.deta) begin
          $error("grad_eta: expected %0d, got %0d", want.deta, grad_eta_o);
          failed = 1'b1;
        end
        if (last_node_o !== want.last) begin
          $error("last_node: expected %0d, got %0d", want.last, last_node_o);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int idle;
    // corners, mid-edge nodes, center
    add_point(-16384, -16384, 0);
    add_point(16384, -16384, 0);
    add_point(16384, 16384, 0);
    add_point(-16384, 16384, 0);
    add_point(0, -16384, 0);
    add_point(16384, 0, 0);
    add_point(0, 16384, 0);
    add_point(-16384, 0, 0);
    add_point(0, 0, 0);
    // out of range, saturates to +-1
    add_point(32767, -32768, 0);
    add_point(-32768, 32767, 0);
    add_point(16385, -16385, 0);
    add_point(-16385, 16385, 0);
    // interior and rounding cases
    add_point(16383, -16383, 0);
    add_point(1, -1, 0);
    add_point(-1, 1, 0);
    add_point(8192, -8192, 0);
    add_point(5461, -10923, 0);
    add_point(-8192, 12288, 0);
    add_point(12345, 3, 0);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      case (i * 4 / RAND_ITEMS)
        1:       idle = 64;
        3:       idle = 19;
        default: idle = 0;
      endcase
      add_point(rand_coord(), rand_coord(), idle);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (points_left != 0) @(posedge clk_i);
    while (node_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (failed) begin
      $display("*** FAILED ***");
    end else begin
      $display("*** PASSED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/q8sf_pkg.sv
sv/quad8_shape_function_eval.sv
tb/quad8_shape_function_eval_tb.sv
